// File: hdl/ctcg_pkg.sv
// Shared constants and types for the CTC greedy decoder.
package ctcg_pkg;

  // Defaults for the top-level parameters.
  localparam int VOCAB_MAX_DEF   = 8192;
  localparam int NUM_STREAMS_DEF = 16;
  localparam int SCORE_BITS_DEF  = 16;

  // Fixed field widths on the ports.
  localparam int STREAM_BITS = 4;
  localparam int TOKEN_BITS  = 13;
  localparam int TS_BITS     = 32;
  localparam int RUN_BITS    = 16;
  localparam int BLANK_BITS  = 13;
  localparam int VSZ_BITS    = 14;

  localparam logic [RUN_BITS-1:0] RUN_MAX     = {RUN_BITS{1'b1}};
  localparam logic [VSZ_BITS-1:0] VOCAB_RESET = 14'd8192;

  // Result beat layout: stream, token, timestamp, blank run, zero padding to bytes.
  localparam int OUT_FIELDS = STREAM_BITS + TOKEN_BITS + TS_BITS + RUN_BITS;
  localparam int OUT_DW     = ((OUT_FIELDS + 7) / 8) * 8;

  // Depth of the frame-result queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 1;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_BLANK_ID   = 1'b0,
    CFG_VOCAB_SIZE = 1'b1
  } cfg_reg_t;

endpackage

// File: hdl/ctcg_front.sv
// Front end: running first-maximum argmax over each frame's scores.
module ctcg_front import ctcg_pkg::*; #(
  parameter int VOCAB_MAX   = VOCAB_MAX_DEF,
  parameter int NUM_STREAMS = NUM_STREAMS_DEF,
  parameter int SCORE_BITS  = SCORE_BITS_DEF,
  localparam int IDX_W = $clog2(VOCAB_MAX),
  localparam int SW    = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1,
  localparam int LEN_W = ($clog2(VOCAB_MAX + 1) > VSZ_BITS) ? $clog2(VOCAB_MAX + 1) : VSZ_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_valid,
  output logic                         s_ready,
  input  logic [STREAM_BITS-1:0]       s_stream,
  input  logic signed [SCORE_BITS-1:0] s_score,
  input  logic                         s_last,
  input  logic [LEN_W-1:0]             frame_len,
  output logic                         ev_valid,
  input  logic                         ev_ready,
  output logic [SW-1:0]                ev_stream,
  output logic [IDX_W-1:0]             ev_index,
  output logic                         ev_last
);

  logic [IDX_W-1:0]             cnt;
  logic [IDX_W-1:0]             best_index;
  logic signed [SCORE_BITS-1:0] best_score;
  logic [SW-1:0]                wrap_tab [1 << STREAM_BITS];
  logic                         take;
  logic                         frame_end;
  logic                         accept;

  // Stream ids beyond the configured count wrap round.
  for (genvar g = 0; g < (1 << STREAM_BITS); g++) begin : g_wrap
    assign wrap_tab[g] = SW'(g % NUM_STREAMS);
  end

  assign take      = (cnt == '0) || (s_score > best_score);
  assign frame_end = ((LEN_W'(cnt) + LEN_W'(1)) >= frame_len) || s_last;
  assign s_ready   = ev_ready;
  assign accept    = s_valid && s_ready;

  assign ev_valid  = s_valid && frame_end;
  assign ev_stream = wrap_tab[s_stream];
  assign ev_index  = take ? cnt : best_index;
  assign ev_last   = s_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= frame_end ? '0 : cnt + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && take) begin
      best_score <= s_score;
      best_index <= cnt;
    end
  end

endmodule

// File: hdl/ctcg_queue.sv
// Small first-in first-out queue carrying frame results from front to back.
module ctcg_queue import ctcg_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// File: hdl/ctcg_back.sv
// Back end: repeat suppression, per-stream offsets and blank runs, result register.
module ctcg_back import ctcg_pkg::*; #(
  parameter int VOCAB_MAX   = VOCAB_MAX_DEF,
  parameter int NUM_STREAMS = NUM_STREAMS_DEF,
  localparam int IDX_W = $clog2(VOCAB_MAX),
  localparam int SW    = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1,
  localparam int CMP_W = (IDX_W > BLANK_BITS) ? IDX_W : BLANK_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [BLANK_BITS-1:0]  blank_id,
  input  logic                   ev_valid,
  output logic                   ev_ready,
  input  logic [SW-1:0]          ev_stream,
  input  logic [IDX_W-1:0]       ev_index,
  input  logic                   ev_last,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [STREAM_BITS-1:0] out_stream,
  output logic                   out_emit,
  output logic [TOKEN_BITS-1:0]  out_token,
  output logic [TS_BITS-1:0]     out_ts,
  output logic [RUN_BITS-1:0]    out_run,
  output logic                   out_last
);

  // Per-stream state memories.
  logic [TS_BITS-1:0]     off_mem [NUM_STREAMS];
  logic [RUN_BITS-1:0]    run_mem [NUM_STREAMS];
  logic [NUM_STREAMS-1:0] written;

  // Chunk state shared by all streams.
  logic [TS_BITS-1:0] fic;
  logic [IDX_W-1:0]   prev_token;
  logic               prev_valid;

  // Update stage.
  logic               b_valid;
  logic [SW-1:0]      b_stream;
  logic [IDX_W-1:0]   b_index;
  logic               b_last;
  logic               b_blank;
  logic               b_emit;
  logic [TS_BITS-1:0] b_fic;
  logic [TS_BITS-1:0] b_fic1;
  logic [TS_BITS-1:0] rd_off;
  logic [RUN_BITS-1:0] rd_run;
  logic               rd_written;
  logic               fwd_hit;
  logic [TS_BITS-1:0] fwd_off;
  logic [RUN_BITS-1:0] fwd_run;

  logic               pop;
  logic               b_adv;
  logic               ev_blank;
  logic               ev_emit;
  logic [TS_BITS-1:0] cur_off;
  logic [RUN_BITS-1:0] cur_run;
  logic [TS_BITS-1:0] off_new;
  logic [RUN_BITS-1:0] run_new;
  logic [TS_BITS-1:0] ts_new;

  assign b_adv    = b_valid && (!out_valid || out_ready);
  assign ev_ready = !b_valid || b_adv;
  assign pop      = ev_valid && ev_ready;

  assign ev_blank = (CMP_W'(ev_index) == CMP_W'(blank_id));
  assign ev_emit  = !ev_blank && !(prev_valid && (ev_index == prev_token));

  always_comb begin
    if (fwd_hit) begin
      cur_off = fwd_off;
      cur_run = fwd_run;
    end else if (rd_written) begin
      cur_off = rd_off;
      cur_run = rd_run;
    end else begin
      cur_off = '0;
      cur_run = '0;
    end
    if (b_blank) begin
      run_new = (cur_run == RUN_MAX) ? cur_run : cur_run + RUN_BITS'(1);
    end else begin
      run_new = '0;
    end
    off_new = b_last ? cur_off + b_fic1 : cur_off;
    ts_new  = b_emit ? b_fic + cur_off : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fic        <= '0;
      prev_token <= '0;
      prev_valid <= 1'b0;
      b_valid    <= 1'b0;
      fwd_hit    <= 1'b0;
      written    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        if (ev_last) begin
          fic        <= '0;
          prev_token <= '0;
          prev_valid <= 1'b0;
        end else begin
          fic        <= fic + TS_BITS'(1);
          prev_token <= ev_index;
          prev_valid <= 1'b1;
        end
        b_valid <= 1'b1;
        fwd_hit <= b_adv && (ev_stream == b_stream);
      end else if (b_adv) begin
        b_valid <= 1'b0;
        fwd_hit <= 1'b0;
      end
      if (b_adv) begin
        written[b_stream] <= 1'b1;
        out_valid         <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_stream   <= ev_stream;
      b_index    <= ev_index;
      b_last     <= ev_last;
      b_blank    <= ev_blank;
      b_emit     <= ev_emit;
      b_fic      <= fic;
      b_fic1     <= fic + TS_BITS'(1);
      rd_off     <= off_mem[ev_stream];
      rd_run     <= run_mem[ev_stream];
      rd_written <= written[ev_stream];
      fwd_off    <= off_new;
      fwd_run    <= run_new;
    end
    if (b_adv) begin
      off_mem[b_stream] <= off_new;
      run_mem[b_stream] <= run_new;
      out_stream        <= STREAM_BITS'(b_stream);
      out_emit          <= b_emit;
      out_token         <= TOKEN_BITS'(b_index);
      out_ts            <= ts_new;
      out_run           <= run_new;
      out_last          <= b_last;
    end
  end

  // An emitted token is never a blank, so its stream's blank run is zero.
  a_emit_clears_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_emit |-> out_run == '0)
    else $error("emitted token carries a non-zero blank run");

  // The end of a chunk forgets the previous winner.
  a_chunk_end_forgets: assert property (@(posedge clk) disable iff (rst)
    pop && ev_last |=> !prev_valid && fic == '0)
    else $error("chunk state not cleared at chunk end");

  // Forwarded state only ever stands beside a live update.
  a_fwd_live: assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> b_valid)
    else $error("forwarded stream state without an update in flight");

endmodule

// File: hdl/ctc_greedy_decoder_unit.sv
// Top level of the CTC greedy decoder: configuration registers, front, queue and back.
//
// Usage. Scores arrive on the s_ channel, one beat per vocabulary entry, frame after
// frame; s_tlast marks the final score of a stream's chunk. A frame ends after the
// configured vocabulary size in scores (zero counts as one, values above VOCAB_MAX
// saturate) or on s_tlast. Each frame yields one result beat on the m_ channel: the
// argmax token, its stream, the trailing blank count and, when m_tuser is high, a
// timestamp for a newly emitted non-blank token; m_tlast marks the chunk's last frame.
// The cfg_ channel writes the blank index (index 0) and the vocabulary size (index 1);
// cfg_ready is always high, and writes are meant to arrive while no frame is in flight.
// Throughput: one score beat per cycle, sustained, with back-to-back frames of any
// length down to one score. The front argmax compare and the back's read-modify-write
// of the per-stream offset and blank-run memories, with forwarding between
// consecutive frames of the same stream, set that rate. A frame's result passes
// through the frame queue, the back's update stage and the result register to m_.
// When the receiver stalls, the result register holds its beat, the back stage and
// a four-entry frame queue absorb further frames, and s_tready falls only when the
// queue is full. Reset (rst, synchronous) clears the argmax, the chunk state, all
// per-stream offsets and blank runs, and restores blank index 0 and vocabulary size
// 8192; no clearing pass is needed, so the block accepts scores in the cycle after reset.
module ctc_greedy_decoder_unit import ctcg_pkg::*; #(
  parameter int VOCAB_MAX   = VOCAB_MAX_DEF,
  parameter int NUM_STREAMS = NUM_STREAMS_DEF,
  parameter int SCORE_BITS  = SCORE_BITS_DEF,
  localparam int IN_DW = ((STREAM_BITS + SCORE_BITS + 7) / 8) * 8
) (
  input  logic                    clk,
  input  logic                    rst,
  // Score beats.
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [IN_DW-1:0]        s_tdata,  // stream_id, score, zero padding
  input  logic                    s_tlast,  // last_of_chunk
  // Frame results.
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [OUT_DW-1:0]       m_tdata,  // out_stream, token, timestamp, trailing_blanks, pad
  output logic                    m_tuser,  // token_valid
  output logic                    m_tlast,  // chunk_done
  // Configuration writes.
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [VSZ_BITS-1:0]     cfg_data
);

  localparam int IDX_W = $clog2(VOCAB_MAX);
  localparam int SW    = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int LEN_W = ($clog2(VOCAB_MAX + 1) > VSZ_BITS) ? $clog2(VOCAB_MAX + 1) : VSZ_BITS;
  localparam int EV_W  = SW + IDX_W + 1;

  logic [BLANK_BITS-1:0] blank_id;
  logic [VSZ_BITS-1:0]   vocab_len;
  logic [LEN_W-1:0]      vocab_ext;
  logic [LEN_W-1:0]      frame_len;

  logic                  fe_valid;
  logic                  fe_ready;
  logic [SW-1:0]         fe_stream;
  logic [IDX_W-1:0]      fe_index;
  logic                  fe_last;
  logic                  bk_valid;
  logic                  bk_ready;
  logic [EV_W-1:0]       bk_data;

  logic [STREAM_BITS-1:0] res_stream;
  logic [TOKEN_BITS-1:0]  res_token;
  logic [TS_BITS-1:0]     res_ts;
  logic [RUN_BITS-1:0]    res_run;

  // Configuration registers; the port never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blank_id  <= '0;
      vocab_len <= VOCAB_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BLANK_ID:   blank_id  <= cfg_data[BLANK_BITS-1:0];
        CFG_VOCAB_SIZE: vocab_len <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Frame length: a zero size counts as one, oversize saturates at VOCAB_MAX.
  assign vocab_ext = LEN_W'(vocab_len);

  always_comb begin
    if (vocab_ext == '0) begin
      frame_len = LEN_W'(1);
    end else if (vocab_ext > LEN_W'(VOCAB_MAX)) begin
      frame_len = LEN_W'(VOCAB_MAX);
    end else begin
      frame_len = vocab_ext;
    end
  end

  ctcg_front #(
    .VOCAB_MAX   (VOCAB_MAX),
    .NUM_STREAMS (NUM_STREAMS),
    .SCORE_BITS  (SCORE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_valid   (s_tvalid),
    .s_ready   (s_tready),
    .s_stream  (s_tdata[STREAM_BITS-1:0]),
    .s_score   (signed'(s_tdata[STREAM_BITS +: SCORE_BITS])),
    .s_last    (s_tlast),
    .frame_len (frame_len),
    .ev_valid  (fe_valid),
    .ev_ready  (fe_ready),
    .ev_stream (fe_stream),
    .ev_index  (fe_index),
    .ev_last   (fe_last)
  );

  ctcg_queue #(
    .WIDTH (EV_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fe_valid),
    .wr_ready (fe_ready),
    .wr_data  ({fe_last, fe_index, fe_stream}),
    .rd_valid (bk_valid),
    .rd_ready (bk_ready),
    .rd_data  (bk_data)
  );

  ctcg_back #(
    .VOCAB_MAX   (VOCAB_MAX),
    .NUM_STREAMS (NUM_STREAMS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .blank_id   (blank_id),
    .ev_valid   (bk_valid),
    .ev_ready   (bk_ready),
    .ev_stream  (bk_data[SW-1:0]),
    .ev_index   (bk_data[SW +: IDX_W]),
    .ev_last    (bk_data[EV_W-1]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_stream (res_stream),
    .out_emit   (m_tuser),
    .out_token  (res_token),
    .out_ts     (res_ts),
    .out_run    (res_run),
    .out_last   (m_tlast)
  );

  // Result beat packing, lowest field first.
  assign m_tdata = {{(OUT_DW - OUT_FIELDS){1'b0}}, res_run, res_ts, res_token, res_stream};

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the CTC greedy decoder: directed frames, register sweeps, random chunks.
module testbench;
  import ctcg_pkg::*;

  localparam int IN_W        = ((STREAM_BITS + SCORE_BITS_DEF + 7) / 8) * 8;
  localparam int TOK_LO      = STREAM_BITS;
  localparam int TS_LO       = TOK_LO + TOKEN_BITS;
  localparam int RUN_LO      = TS_LO + TS_BITS;
  localparam int CYCLE_LIMIT = 1_000_000;
  // A result leaves through the queue, the update stage and the result register; allow some slack.
  localparam int SETTLE      = 8;
  localparam int HOLDOFF_LEN = 400;
  localparam int PRINT_MAX   = 100;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // One frame decision as it leaves the block.
  typedef struct packed {
    logic [STREAM_BITS-1:0] stream;
    logic                   tok_valid;
    logic [TOKEN_BITS-1:0]  token;
    logic [TS_BITS-1:0]     stamp;
    logic [RUN_BITS-1:0]    blanks;
    logic                   done;
  } frame_result_t;

  // Tracks the decoder's argmax and chunk state beat by beat and holds the
  // frame decisions that are still to come out of the block.
  class ctc_frame_scoreboard;
    logic [BLANK_BITS-1:0]  blank_sym;
    logic [VSZ_BITS-1:0]    vocab_reg;
    logic signed [15:0]     run_best;
    logic [TOKEN_BITS-1:0]  run_best_idx;
    int unsigned            scores_in_frame;
    logic [31:0]            frames_in_chunk;
    logic [TOKEN_BITS-1:0]  last_winner;
    bit                     last_winner_ok;
    logic [31:0]            stream_offset [16];
    logic [RUN_BITS-1:0]    stream_blanks [16];
    frame_result_t          pending_frames [$];
    int                     mismatches;
    int                     frames_checked;
    int                     tokens_seen;
    int                     chunks_seen;
    int                     beats_noted;
    logic [RUN_BITS-1:0]    peak_blanks;

    function new();
      blank_sym       = '0;
      vocab_reg       = VOCAB_RESET;
      run_best        = '0;
      run_best_idx    = '0;
      scores_in_frame = 0;
      frames_in_chunk = '0;
      last_winner     = '0;
      last_winner_ok  = 1'b0;
      foreach (stream_offset[i]) stream_offset[i] = '0;
      foreach (stream_blanks[i]) stream_blanks[i] = '0;
      mismatches      = 0;
      frames_checked  = 0;
      tokens_seen     = 0;
      chunks_seen     = 0;
      beats_noted     = 0;
      peak_blanks     = '0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [VSZ_BITS-1:0] val);
      if (idx == CFG_BLANK_ID) begin
        blank_sym = val[BLANK_BITS-1:0];
      end else begin
        vocab_reg = val;
      end
    endfunction

    // Zero counts as one score per frame, anything above the maximum saturates.
    function int unsigned frame_length();
      if (vocab_reg == 0) return 1;
      if (vocab_reg > VOCAB_MAX_DEF) return VOCAB_MAX_DEF;
      return 32'(vocab_reg);
    endfunction

    function int unsigned pending();
      return pending_frames.size();
    endfunction

    function void note_score(logic [STREAM_BITS-1:0] sid, logic signed [15:0] sc, bit last);
      frame_result_t         r;
      logic [TOKEN_BITS-1:0] win;
      bit                    fresh;
      beats_noted++;
      // The first score of a frame always takes the lead; later ones only when strictly higher.
      if (scores_in_frame == 0 || sc > run_best) begin
        run_best     = sc;
        run_best_idx = TOKEN_BITS'(scores_in_frame);
      end
      scores_in_frame++;
      if (scores_in_frame < frame_length() && !last) return;

      win = run_best_idx;
      if (win == blank_sym) begin
        if (stream_blanks[sid] != RUN_MAX) stream_blanks[sid]++;
      end else begin
        stream_blanks[sid] = '0;
      end
      fresh       = (win != blank_sym) && !(last_winner_ok && win == last_winner);
      r.stream    = sid;
      r.tok_valid = fresh;
      r.token     = win;
      r.stamp     = fresh ? frames_in_chunk + stream_offset[sid] : '0;
      r.blanks    = stream_blanks[sid];
      r.done      = last;
      pending_frames.insert(pending_frames.size(), r);

      last_winner     = win;
      last_winner_ok  = 1'b1;
      frames_in_chunk++;
      scores_in_frame = 0;
      run_best        = '0;
      run_best_idx    = '0;
      if (last) begin
        stream_offset[sid] += frames_in_chunk;
        frames_in_chunk = '0;
        last_winner_ok  = 1'b0;
        last_winner     = '0;
      end
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (mismatches < PRINT_MAX)
        $display("mismatch: %s at frame %0d: got 0x%0h, expected 0x%0h",
                 what, frames_checked, got, want);
      mismatches++;
    endtask

    task check_result(frame_result_t got);
      frame_result_t want;
      if (pending_frames.size() == 0) begin
        report_mismatch("result beat with no frame pending", got.token, 0);
        return;
      end
      want = pending_frames.pop_front();
      if (got.stream != want.stream)       report_mismatch("out_stream", got.stream, want.stream);
      if (got.tok_valid != want.tok_valid) report_mismatch("token_valid", got.tok_valid,
                                                           want.tok_valid);
      if (got.token != want.token)         report_mismatch("token", got.token, want.token);
      if (got.stamp != want.stamp)         report_mismatch("timestamp", got.stamp, want.stamp);
      if (got.blanks != want.blanks)       report_mismatch("trailing_blanks", got.blanks,
                                                           want.blanks);
      if (got.done != want.done)           report_mismatch("chunk_done", got.done, want.done);
      frames_checked++;
      tokens_seen += got.tok_valid;
      chunks_seen += got.done;
      if (got.blanks > peak_blanks) peak_blanks = got.blanks;
    endtask
  endclass

  logic                    clk;
  logic                    rst;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [IN_W-1:0]         s_tdata;   // stream_id, score, zero padding
  logic                    s_tlast;   // last_of_chunk
  logic                    m_tvalid;
  logic                    m_tready;
  logic [OUT_DW-1:0]       m_tdata;   // out_stream, token, timestamp, trailing_blanks, pad
  logic                    m_tuser;   // token_valid
  logic                    m_tlast;   // chunk_done
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [VSZ_BITS-1:0]     cfg_data;

  ctc_frame_scoreboard sb = new();

  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int holdoff_request = 0;
  int holdoff_taken   = 0;
  int holdoff_left    = 0;
  int cycle_count     = 0;
  int settings_run    = 0;

  ctc_greedy_decoder_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, or a long hold-off on request so that the block
  // backs up all the way to its input.
  always @(posedge clk) begin
    if (holdoff_left > 0) begin
      holdoff_left--;
      m_tready <= 1'b0;
    end else if (holdoff_taken != holdoff_request) begin
      holdoff_taken = holdoff_request;
      holdoff_left  = HOLDOFF_LEN;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Every accepted result beat is unpacked and checked against the oldest decision.
  always @(posedge clk) begin
    frame_result_t got;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      got.stream    = m_tdata[STREAM_BITS-1:0];
      got.token     = m_tdata[TOK_LO +: TOKEN_BITS];
      got.stamp     = m_tdata[TS_LO +: TS_BITS];
      got.blanks    = m_tdata[RUN_LO +: RUN_BITS];
      got.tok_valid = m_tuser;
      got.done      = m_tlast;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ctc_greedy_decoder_unit test failed");
      $finish;
    end
  end

  task automatic set_idling(idle_mode_t m);
    case (m)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct  = 72;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = 72;
      end
      default: begin
        send_idle_pct  = 9;
        recv_stall_pct = 9;
      end
    endcase
  endtask

  // One score beat; tvalid stays high afterwards so back-to-back beats need no gap.
  task automatic send_score(logic [STREAM_BITS-1:0] sid, logic signed [15:0] sc, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_W'({sc, sid});
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_score(sid, sc, last);
  endtask

  // Stops offering beats and waits for every pending decision to come out.
  task automatic drain_results(int settle);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [VSZ_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(logic [VSZ_BITS-1:0] blank_word, logic [VSZ_BITS-1:0] vocab_word);
    drain_results(SETTLE);
    write_reg(CFG_BLANK_ID, blank_word);
    write_reg(CFG_VOCAB_SIZE, vocab_word);
    settings_run++;
  endtask

  // One frame of len scores. Mostly the winner is planted: often the blank or a
  // repeat of the previous winner, sometimes with equal scores after it to test
  // that the first maximum wins. A few frames are plain noise.
  task automatic send_frame(logic [STREAM_BITS-1:0] sid, int unsigned len, bit ends_chunk,
                            int forced);
    int unsigned            target;
    int                     kind;
    int                     hi;
    int                     v;
    bit                     noise;
    bit                     tie_after;
    logic [STREAM_BITS-1:0] s;
    kind  = $urandom_range(99);
    noise = 1'b0;
    if (forced >= 0) begin
      target = forced;
    end else begin
      noise = (kind >= 88);
      if (kind < 35 && sb.blank_sym < len) target = sb.blank_sym;
      else if (kind < 60 && sb.last_winner_ok && sb.last_winner < len) target = sb.last_winner;
      else target = $urandom_range(len - 1);
    end
    tie_after = ($urandom_range(99) < 20);
    hi        = int'($urandom_range(65534)) - 32767;
    for (int unsigned i = 0; i < len; i++) begin
      // Now and then the stream id changes inside a frame.
      s = ($urandom_range(99) < 8) ? STREAM_BITS'($urandom) : sid;
      if (noise) v = int'($urandom_range(65535)) - 32768;
      else if (i == target || (tie_after && i > target)) v = hi;
      else v = hi - 1 - int'($urandom_range(hi + 32767));
      send_score(s, 16'(v), ends_chunk && (i == len - 1));
    end
  endtask

  // Whole chunks of one to six frames; the last frame is sometimes cut short by tlast.
  task automatic run_chunks(int n_items, bit pause_midway);
    int                     sent;
    int unsigned            nf;
    int unsigned            flen;
    int unsigned            len;
    bit                     paused;
    logic [STREAM_BITS-1:0] sid;
    sent   = 0;
    paused = 1'b0;
    flen   = sb.frame_length();
    while (sent < n_items) begin
      sid = $urandom_range(1) ? STREAM_BITS'($urandom_range(3)) : STREAM_BITS'($urandom);
      nf  = $urandom_range(6, 1);
      // Keep the phase close to its share of beats.
      if (int'(nf * flen) > n_items - sent) begin
        nf = 32'((n_items - sent + int'(flen) - 1) / int'(flen));
      end
      for (int unsigned f = 0; f < nf; f++) begin
        len = flen;
        if (f == nf - 1 && flen > 1 && $urandom_range(99) < 20) len = $urandom_range(flen - 1, 1);
        send_frame(sid, len, f == nf - 1, -1);
        sent += len;
        if (pause_midway && !paused && sent >= n_items / 2) begin
          // The sender waits here, after a frame, until every result has come out.
          drain_results(0);
          paused = 1'b1;
        end
      end
    end
  endtask

  task automatic run_phase(logic [VSZ_BITS-1:0] blank_word, logic [VSZ_BITS-1:0] vocab_word,
                           idle_mode_t m, int n_items, bit hold, bit pause_midway);
    set_regs(blank_word, vocab_word);
    set_idling(m);
    if (hold) holdoff_request++;
    run_chunks(n_items, pause_midway);
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_BLANK_ID;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings: blank 0, frames of 8192 that end
    // early on tlast.
    set_idling(IDLE_NONE);
    send_score(4'd0, 16'sh7FFF, 1'b1);      // lone score, index 0 is the blank
    send_score(4'd1, -16'sd32768, 1'b0);
    send_score(4'd1, 16'sh7FFF, 1'b0);
    send_score(4'd1, 16'sh7FFF, 1'b1);      // tie at the maximum, the first one wins
    send_score(4'd2, -16'sd1, 1'b0);
    send_score(4'd3, 16'sd100, 1'b1);       // stream changes inside the frame
    send_score(4'd15, 16'sd0, 1'b1);
    send_score(4'd1, 16'sd0, 1'b0);
    send_score(4'd1, 16'sd0, 1'b1);         // all equal, the blank at index 0 wins
    send_score(4'd1, -16'sd5, 1'b0);
    send_score(4'd1, 16'sd3, 1'b1);         // token stamped with the stream's offset

    // Vocabulary size zero behaves as one score per frame.
    set_regs(14'd0, 14'd0);
    send_score(4'd9, 16'sh1234, 1'b0);
    send_score(4'd10, -16'sd32767, 1'b1);

    // Blank above the vocabulary never wins; repeats are still suppressed.
    set_regs(14'd7, 14'd2);
    send_score(4'd4, 16'sd1, 1'b0);
    send_score(4'd4, 16'sd9, 1'b0);
    send_score(4'd4, 16'sd3, 1'b0);
    send_score(4'd4, 16'sd2, 1'b0);
    send_score(4'd4, 16'sd0, 1'b0);
    send_score(4'd4, 16'sd8, 1'b0);
    send_score(4'd4, 16'sd4, 1'b0);
    send_score(4'd4, 16'sd4, 1'b0);
    send_score(4'd4, 16'sd2, 1'b0);
    send_score(4'd4, 16'sd9, 1'b0);
    send_score(4'd4, 16'sd2, 1'b0);
    send_score(4'd4, 16'sd9, 1'b1);

    // Random chunks over a spread of settings and idling patterns. The first
    // phase starts with a long receiver hold-off; the third pauses the sender.
    run_phase(14'd0, 14'd4, IDLE_NONE, 130, 1'b1, 1'b0);
    run_phase(14'd3, 14'd8, IDLE_SENDER, 130, 1'b0, 1'b0);
    run_phase(14'd1, 14'd2, IDLE_RECEIVER, 120, 1'b0, 1'b1);
    run_phase(14'd0, 14'd0, IDLE_BOTH, 80, 1'b0, 1'b0);
    run_phase(14'd5, 14'd3, IDLE_NONE, 100, 1'b0, 1'b0);
    run_phase(14'h2002, 14'd5, IDLE_SENDER, 110, 1'b0, 1'b0);  // upper data bit is dropped
    run_phase(14'd13, 14'd16, IDLE_RECEIVER, 130, 1'b0, 1'b0);
    run_phase(14'd150, 14'd200, IDLE_BOTH, 190, 1'b0, 1'b0);

    // A size above the maximum saturates, so these frames only end on tlast. The
    // blank sits at the top index and never wins; the first winner is the last
    // score of its frame.
    set_regs(14'h1FFF, 14'h3FFF);
    set_idling(IDLE_NONE);
    send_frame(4'd11, 24, 1'b1, 23);
    send_frame(4'd11, 13, 1'b1, -1);

    drain_results(SETTLE * 2);
    $display("Covered %0d score beats and %0d frame results, %0d of them tokens, %0d chunk ends.",
             sb.beats_noted, sb.frames_checked, sb.tokens_seen, sb.chunks_seen);
    $display("Ran %0d register settings after the reset one; the blank run peaked at %0d.",
             settings_run, sb.peak_blanks);
    if (sb.mismatches == 0) begin
      $display("ctc_greedy_decoder_unit test passed");
    end else begin
      $display("ctc_greedy_decoder_unit test failed");
    end
    $finish;
  end

endmodule
